>>> hdl/assert_macros.svh
// Assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high
`define PFMA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define PFMA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/pfma_pkg.sv
// Types and constants shared by the flow meter modules
package pfma_pkg;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PULSES_PER_LITER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL_MS  = 1'd1;

   localparam logic [15:0] PPL_RESET      = 16'd450;
   localparam logic [15:0] MIN_INT_RESET  = 16'd100;

   localparam logic [15:0] FLOW_MULT      = 16'd60000;
   localparam logic [6:0]  CENTI_MULT     = 7'd100;
   localparam logic [38:0] ROUND_HALF     = 39'd32768;
   localparam logic [31:0] FLOW_SAT       = 32'hFFFF_FFFF;
   localparam logic [15:0] CENTI_SAT      = 16'hFFFF;
   localparam logic [47:0] TOTAL_SAT      = 48'hFFFF_FFFF_FFFF;
   localparam logic [39:0] ML_SAT         = 40'hFF_FFFF_FFFF;

   // shared divider geometry
   localparam int DIV_DVD_W = 64;
   localparam int DIV_DEN_W = 48;
   localparam int DIV_CNT_W = 7;
   localparam logic [DIV_CNT_W-1:0] FLOW_STEPS = 7'd32;
   localparam logic [DIV_CNT_W-1:0] TOT_STEPS  = 7'd58;

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_CALC      = 12'b0000_0000_0010,
      ST_CHECK     = 12'b0000_0000_0100,
      ST_FLOW      = 12'b0000_0000_1000,
      ST_FLOW_WAIT = 12'b0000_0001_0000,
      ST_UPDATE    = 12'b0000_0010_0000,
      ST_AVG       = 12'b0000_0100_0000,
      ST_AVG_WAIT  = 12'b0000_1000_0000,
      ST_CENTI     = 12'b0001_0000_0000,
      ST_TOT       = 12'b0010_0000_0000,
      ST_TOT_WAIT  = 12'b0100_0000_0000,
      ST_OUT       = 12'b1000_0000_0000
   } pfma_state_type;

   typedef struct packed {
      logic load;
      logic calc;
      logic mul;
      logic flow_start;
      logic flow_take;
      logic update;
      logic avg_start;
      logic avg_take;
      logic centi;
      logic tot_start;
      logic tot_take;
      logic out_load;
   } pfma_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic sample_ok;
      logic flow_special;
      logic tot_zero;
      logic div_done;
   } pfma_status_type;

endpackage

>>> hdl/pfma_div.sv
// Restoring divider, one quotient bit per cycle
module pfma_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pfma_pkg::DIV_DEN_W-1:0] init_rem,
   input  logic [pfma_pkg::DIV_DVD_W-1:0] dividend,
   input  logic [pfma_pkg::DIV_DEN_W-1:0] divisor,
   input  logic [pfma_pkg::DIV_CNT_W-1:0] steps,
   output logic                           done,
   output logic [pfma_pkg::DIV_DVD_W-1:0] quotient
);
   import pfma_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DVD_W-1:0] dvd_ff, dvd_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DVD_W-1:0] quo_ff, quo_in;

   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 ge;

   assign trial = {rem_ff, dvd_ff[DIV_DVD_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         rem_in  = init_rem;
         dvd_in  = dividend;
         den_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so its top bit drops safely
         rem_in = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         dvd_in = {dvd_ff[DIV_DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/pfma_datapath.sv
// Datapath: measurement state, multipliers, shared divider and result register
module pfma_datapath #(
   parameter int HISTORY_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pfma_pkg::pfma_cmd_type          cmd,
   output pfma_pkg::pfma_status_type       status,
   input  logic                            csr_write_en,
   input  logic [pfma_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pfma_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_opcode,
   input  logic [31:0]                     req_now_ms,
   input  logic [31:0]                     req_pulse_counter,
   output logic                            rsp_status,
   output logic [31:0]                     rsp_pulse_delta,
   output logic [15:0]                     rsp_flow_centi,
   output logic [39:0]                     rsp_total_milliliters
);
   import pfma_pkg::*;

   localparam int SUM_W  = 32 + $clog2(HISTORY_DEPTH);
   localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

   // configuration
   logic [15:0] ppl_ff;
   logic [15:0] min_ff;

   // latched request
   logic        opcode_ff;
   logic [31:0] now_ff;
   logic [31:0] cnt_ff;

   // per-item working registers
   logic [31:0] delta_ff;
   logic [31:0] elapsed_ff;
   logic        ok_ff;
   logic [47:0] num_ff;
   logic [47:0] den_ff;
   logic [31:0] flow_ff;
   logic [38:0] centi_prod_ff;
   logic [39:0] tot_ml_ff;

   // measurement state
   logic [31:0]       last_ff;
   logic [31:0]       snap_ff;
   logic [31:0]       hist_ff [HISTORY_DEPTH];
   logic [SUM_W-1:0]  sum_ff;
   logic [IDX_W-1:0]  ring_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [47:0]       total_ff;
   logic [31:0]       held_delta_ff;
   logic [15:0]       held_centi_ff;

   // result register
   logic        rsp_status_ff;
   logic [31:0] rsp_delta_ff;
   logic [15:0] rsp_centi_ff;
   logic [39:0] rsp_total_ff;

   logic [31:0]       elapsed_in;
   logic              flow_special;
   logic [31:0]       flow_special_val;
   logic [SUM_W-1:0]  sum_in;
   logic [48:0]       total_sum;
   logic [47:0]       total_in;
   logic [IDX_W-1:0]  ring_in;
   logic [FILL_W-1:0] fill_in;
   logic [38:0]       rounded;
   logic [15:0]       centi_in;
   logic [57:0]       total_x1000;
   logic              tot_zero;

   logic                  div_start;
   logic [DIV_DEN_W-1:0]  div_init;
   logic [DIV_DVD_W-1:0]  div_dvd;
   logic [DIV_DEN_W-1:0]  div_den;
   logic [DIV_CNT_W-1:0]  div_steps;
   logic                  div_done;
   logic [DIV_DVD_W-1:0]  div_quo;

   assign elapsed_in = now_ff - last_ff;

   // zero delta gives zero flow; quotient of 2^16 or more (or zero divisor) saturates
   assign flow_special     = (delta_ff == 32'd0) || ({16'd0, num_ff[47:16]} >= den_ff);
   assign flow_special_val = (delta_ff == 32'd0) ? 32'd0 : FLOW_SAT;

   assign sum_in    = sum_ff - SUM_W'(hist_ff[ring_ff]) + SUM_W'(flow_ff);
   assign total_sum = {1'b0, total_ff} + {17'd0, delta_ff};
   assign total_in  = total_sum[48] ? TOTAL_SAT : total_sum[47:0];
   assign ring_in   = (ring_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : ring_ff + 1'b1;
   assign fill_in   = (fill_ff == FILL_W'(HISTORY_DEPTH)) ? fill_ff : fill_ff + 1'b1;

   assign rounded  = centi_prod_ff + ROUND_HALF;
   assign centi_in = (|rounded[38:32]) ? CENTI_SAT : rounded[31:16];

   // total * 1000 as 1024 - 16 - 8
   assign total_x1000 = ({10'd0, total_ff} << 10) - ({10'd0, total_ff} << 4)
                      - ({10'd0, total_ff} << 3);
   assign tot_zero    = (total_ff == 48'd0);

   assign div_start = (cmd.flow_start & ~flow_special) | cmd.avg_start
                    | (cmd.tot_start & ~tot_zero);

   always_comb begin
      if (cmd.flow_start) begin
         div_init  = {16'd0, num_ff[47:16]};
         div_dvd   = {num_ff[15:0], 48'd0};
         div_den   = den_ff;
         div_steps = FLOW_STEPS;
      end else if (cmd.avg_start) begin
         div_init  = '0;
         div_dvd   = DIV_DVD_W'(sum_ff) << (DIV_DVD_W - SUM_W);
         div_den   = DIV_DEN_W'(fill_ff);
         div_steps = DIV_CNT_W'(SUM_W);
      end else begin
         div_init  = '0;
         div_dvd   = {total_x1000, 6'd0};
         div_den   = {32'd0, ppl_ff};
         div_steps = TOT_STEPS;
      end
   end

   pfma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .init_rem (div_init),
      .dividend (div_dvd),
      .divisor  (div_den),
      .steps    (div_steps),
      .done     (div_done),
      .quotient (div_quo)
   );

   // configuration and measurement state
   always_ff @(posedge clock) begin
      if (reset) begin
         ppl_ff        <= PPL_RESET;
         min_ff        <= MIN_INT_RESET;
         last_ff       <= '0;
         snap_ff       <= '0;
         sum_ff        <= '0;
         ring_ff       <= '0;
         fill_ff       <= '0;
         total_ff      <= '0;
         held_delta_ff <= '0;
         held_centi_ff <= '0;
         ok_ff         <= 1'b0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_PULSES_PER_LITER: ppl_ff <= csr_wdata;
               CSR_MIN_INTERVAL_MS:  min_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.calc) begin
            if (!opcode_ff) begin
               // clear: restart with this timestamp and counter value
               last_ff       <= now_ff;
               snap_ff       <= cnt_ff;
               sum_ff        <= '0;
               ring_ff       <= '0;
               fill_ff       <= '0;
               total_ff      <= '0;
               held_delta_ff <= '0;
               held_centi_ff <= '0;
               ok_ff         <= 1'b0;
               for (int i = 0; i < HISTORY_DEPTH; i++) begin
                  hist_ff[i] <= '0;
               end
            end else begin
               ok_ff <= (elapsed_in >= {16'd0, min_ff});
            end
         end
         if (cmd.update) begin
            last_ff          <= now_ff;
            snap_ff          <= cnt_ff;
            held_delta_ff    <= delta_ff;
            total_ff         <= total_in;
            sum_ff           <= sum_in;
            hist_ff[ring_ff] <= flow_ff;
            ring_ff          <= ring_in;
            fill_ff          <= fill_in;
         end
         if (cmd.centi) begin
            held_centi_ff <= centi_in;
         end
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opcode_ff <= req_opcode;
         now_ff    <= req_now_ms;
         cnt_ff    <= req_pulse_counter;
      end
      if (cmd.calc) begin
         delta_ff   <= cnt_ff - snap_ff;
         elapsed_ff <= elapsed_in;
      end
      if (cmd.mul) begin
         num_ff <= delta_ff * FLOW_MULT;
         den_ff <= elapsed_ff * ppl_ff;
      end
      if (cmd.flow_start && flow_special) begin
         flow_ff <= flow_special_val;
      end else if (cmd.flow_take) begin
         flow_ff <= div_quo[31:0];
      end
      if (cmd.avg_take) begin
         centi_prod_ff <= div_quo[31:0] * CENTI_MULT;
      end
      if (cmd.tot_start && tot_zero) begin
         tot_ml_ff <= '0;
      end else if (cmd.tot_take) begin
         tot_ml_ff <= (|div_quo[57:40]) ? ML_SAT : div_quo[39:0];
      end
      if (cmd.out_load) begin
         rsp_status_ff <= ok_ff & opcode_ff;
         rsp_delta_ff  <= held_delta_ff;
         rsp_centi_ff  <= held_centi_ff;
         rsp_total_ff  <= tot_ml_ff;
      end
   end

   assign status.is_clear     = ~opcode_ff;
   assign status.sample_ok    = ok_ff;
   assign status.flow_special = flow_special;
   assign status.tot_zero     = tot_zero;
   assign status.div_done     = div_done;

   assign rsp_status            = rsp_status_ff;
   assign rsp_pulse_delta       = rsp_delta_ff;
   assign rsp_flow_centi        = rsp_centi_ff;
   assign rsp_total_milliliters = rsp_total_ff;

endmodule

>>> hdl/pfma_ctrl.sv
// Controller: sequences one item through the datapath and owns both handshakes
module pfma_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  pfma_pkg::pfma_status_type  status,
   output pfma_pkg::pfma_cmd_type     cmd
);
   import pfma_pkg::*;

   pfma_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = status.is_clear ? ST_TOT : ST_CHECK;
         end
         ST_CHECK: begin
            if (status.sample_ok) begin
               cmd.mul  = 1'b1;
               state_in = ST_FLOW;
            end else begin
               state_in = ST_TOT;
            end
         end
         ST_FLOW: begin
            cmd.flow_start = 1'b1;
            state_in       = status.flow_special ? ST_UPDATE : ST_FLOW_WAIT;
         end
         ST_FLOW_WAIT: begin
            if (status.div_done) begin
               cmd.flow_take = 1'b1;
               state_in      = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_AVG;
         end
         ST_AVG: begin
            cmd.avg_start = 1'b1;
            state_in      = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (status.div_done) begin
               cmd.avg_take = 1'b1;
               state_in     = ST_CENTI;
            end
         end
         ST_CENTI: begin
            cmd.centi = 1'b1;
            state_in  = ST_TOT;
         end
         ST_TOT: begin
            cmd.tot_start = 1'b1;
            state_in      = status.tot_zero ? ST_OUT : ST_TOT_WAIT;
         end
         ST_TOT_WAIT: begin
            if (status.div_done) begin
               cmd.tot_take = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            // result register free or being drained this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/pulse_flow_meter_averaged.sv
// Top level of the averaging pulse flow meter
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_stall    opcode, now_ms, pulse_counter
//   rsp      out  rsp_valid/rsp_stall    status, pulse_delta, flow_centi, total_ml
//   csr      in   csr_write_en           csr_index, csr_wdata
//
// One item at a time; all divisions share the one-bit-per-cycle divider.
// New sample: flow, average and total divisions in turn; the flow division is skipped when
// the flow is zero or saturates. Interval too short: total division only (none at zero total).
// Clear: no division. The next request can be taken in the cycle after the result is loaded.
// Reset is synchronous; it restores the register defaults and zeros the measurement state.
// A stalled result stays in the output register while the next item is taken in.
module pulse_flow_meter_averaged #(
   parameter int HISTORY_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [31:0]                     req_now_ms,
   input  logic [31:0]                     req_pulse_counter,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_status,
   output logic [31:0]                     rsp_pulse_delta,
   output logic [15:0]                     rsp_flow_centi,
   output logic [39:0]                     rsp_total_milliliters,
   input  logic                            csr_write_en,
   input  logic [pfma_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pfma_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pfma_pkg::*;

   pfma_cmd_type    cmd;
   pfma_status_type status;

   pfma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pfma_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_opcode            (req_opcode),
      .req_now_ms            (req_now_ms),
      .req_pulse_counter     (req_pulse_counter),
      .rsp_status            (rsp_status),
      .rsp_pulse_delta       (rsp_pulse_delta),
      .rsp_flow_centi        (rsp_flow_centi),
      .rsp_total_milliliters (rsp_total_milliliters)
   );

endmodule

>>> hdl/pfma_checker.sv
// Port-level checks for the flow meter, bound to the top level
`include "assert_macros.svh"

module pfma_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_opcode,
   input logic [31:0] req_now_ms,
   input logic [31:0] req_pulse_counter,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_status,
   input logic [31:0] rsp_pulse_delta,
   input logic [15:0] rsp_flow_centi,
   input logic [39:0] rsp_total_milliliters
);

   logic [65:0] req_held;
   logic [88:0] rsp_payload;

   assign req_held    = {req_valid, req_opcode, req_now_ms, req_pulse_counter};
   assign rsp_payload = {rsp_status, rsp_pulse_delta, rsp_flow_centi, rsp_total_milliliters};

   // after reset the block is empty and ready for a request
   `PFMA_ASSERT_ALWAYS(a_reset_idle, reset |=> (!rsp_valid && !req_stall), "not idle after reset")

   // one item in flight: a request transfer closes the input side
   `PFMA_ASSERT(a_one_in_flight, (req_valid && !req_stall) |=> req_stall, "second item taken early")

   `PFMA_ASSERT(a_req_hold, (req_valid && req_stall) |=> $stable(req_held), "request not held")

   `PFMA_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> rsp_valid, "stalled result dropped")

   `PFMA_ASSERT(a_rsp_stable, (rsp_valid && rsp_stall) |=> $stable(rsp_payload), "result not held")

endmodule

bind pulse_flow_meter_averaged pfma_checker u_pfma_checker (.*);
